// File: rtl/encoder_sector_quadratic_pwm_macros.svh
// ----------------------------------------------------------------------------
// encoder_sector_quadratic_pwm_macros
// Assertion macros shared by the commutation block. They use the clock i_clk
// and the active-low reset i_rst_n of the module that expands them.
// ----------------------------------------------------------------------------
`ifndef ENCODER_SECTOR_QUADRATIC_PWM_MACROS_SVH
`define ENCODER_SECTOR_QUADRATIC_PWM_MACROS_SVH

// same-cycle implication
`define ESQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ESQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/esq_pkg.sv
// ----------------------------------------------------------------------------
// esq_pkg
// Types, constants and helper functions of the sector commutation pipeline.
// ----------------------------------------------------------------------------
package esq_pkg;

    localparam int CHANNELS    = 3;
    localparam int SECTORS     = 2 * CHANNELS;
    localparam int TABLE_DEPTH = SECTORS * CHANNELS;

    localparam int SEC_W   = 3;
    localparam int LANE_W  = 2;
    localparam int IDX_W   = 5;
    localparam int RES_W   = 13;
    localparam int DATA_W  = 16;
    localparam int MID_W   = 10;
    localparam int ANG_W   = 32;
    localparam int PROD_W  = 27;
    localparam int WGT_W   = 16;
    localparam int MUL_W   = 32;
    localparam int BLEND_W = 20;
    localparam int SCALE_W = DATA_W + BLEND_W;

    localparam int SECTOR_FULL = 8192;
    localparam int SECTOR_HALF = 4096;
    localparam int ANGLE_MUL   = 21;
    localparam int CORR_SHIFT  = 16;
    localparam int MID_SHIFT   = 8;
    localparam int WGT_SHIFT   = 12;
    localparam int BLEND_SHIFT = 13;
    localparam int DUTY_SHIFT  = 10;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TABLE  = 1'b1;

    typedef enum logic {
        CFG_ANGLE_OFFSET = 1'b0,
        CFG_MID_WEIGHT   = 1'b1
    } t_cfg_idx;

    typedef logic [CHANNELS-1:0][DATA_W-1:0] t_row;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
        logic s7;
    } t_adv;

    // residue of an 18-bit value modulo 3 (base-4 digit sum)
    function automatic logic [1:0] mod3_18(input logic [17:0] q);
        logic [4:0] s1;
        logic [2:0] s2;
        logic [2:0] m;
        s1 = '0;
        for (int i = 0; i < 9; i++) begin
            s1 = s1 + 5'(q[2*i +: 2]);
        end
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
        if (s2 >= 3'd6) begin
            m = s2 - 3'd6;
        end else if (s2 >= 3'd3) begin
            m = s2 - 3'd3;
        end else begin
            m = s2;
        end
        return m[1:0];
    endfunction

    function automatic logic [SEC_W-1:0] tab_row(input logic [IDX_W-1:0] idx);
        logic [SEC_W-1:0] row;
        row = '0;
        for (int k = 1; k < SECTORS; k++) begin
            if (idx >= IDX_W'(k * CHANNELS)) begin
                row = SEC_W'(k);
            end
        end
        return row;
    endfunction

    function automatic logic [LANE_W-1:0] tab_lane(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] diff;
        base = IDX_W'(tab_row(idx) * CHANNELS);
        diff = idx - base;
        return diff[LANE_W-1:0];
    endfunction

endpackage

// File: rtl/esq_angle.sv
// ----------------------------------------------------------------------------
// esq_angle
// Stages 1 and 2: offset-corrected angle scaling, then sector and residue.
// ----------------------------------------------------------------------------
module esq_angle import esq_pkg::*; (
    input  logic                     i_clk,
    input  t_adv                     i_adv,
    input  logic [DATA_W-1:0]        i_angle_offset,
    input  logic                     i_mode,
    input  logic [DATA_W-1:0]        i_encoder_count,
    input  logic signed [DATA_W-1:0] i_current_cmd,
    input  logic [IDX_W-1:0]         i_table_index,
    input  logic [DATA_W-1:0]        i_table_value,
    output logic [SEC_W-1:0]         o_sector,
    output logic [SEC_W-1:0]         o_next,
    output logic [RES_W-1:0]         o_res,
    output logic signed [DATA_W-1:0] o_cur,
    output logic                     o_mode,
    output logic [IDX_W-1:0]         o_table_index,
    output logic [DATA_W-1:0]        o_table_value
);

    logic [ANG_W-1:0]         n_diff;
    logic [ANG_W-1:0]         n_ang;
    logic [1:0]               n_m3;
    logic [SEC_W-1:0]         n_sec;
    logic [SEC_W-1:0]         n_next;

    logic [ANG_W-1:0]         r1_ang;
    logic signed [DATA_W-1:0] r1_cur;
    logic                     r1_mode;
    logic [IDX_W-1:0]         r1_idx;
    logic [DATA_W-1:0]        r1_val;

    logic [SEC_W-1:0]         r2_sec;
    logic [SEC_W-1:0]         r2_next;
    logic [RES_W-1:0]         r2_res;
    logic signed [DATA_W-1:0] r2_cur;
    logic                     r2_mode;
    logic [IDX_W-1:0]         r2_idx;
    logic [DATA_W-1:0]        r2_val;

    always_comb begin
        n_diff = ANG_W'(i_encoder_count) - ANG_W'(i_angle_offset);
        n_ang  = (n_diff << 4) + (n_diff << 2) + n_diff;
        n_m3   = mod3_18(r1_ang[ANG_W-1:14]);
        n_sec  = {n_m3, r1_ang[RES_W]};
        if (n_sec == SEC_W'(SECTORS - 1)) begin
            n_next = '0;
        end else begin
            n_next = n_sec + SEC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s1) begin
            r1_ang  <= n_ang;
            r1_cur  <= i_current_cmd;
            r1_mode <= i_mode;
            r1_idx  <= i_table_index;
            r1_val  <= i_table_value;
        end
        if (i_adv.s2) begin
            r2_sec  <= n_sec;
            r2_next <= n_next;
            r2_res  <= r1_ang[RES_W-1:0];
            r2_cur  <= r1_cur;
            r2_mode <= r1_mode;
            r2_idx  <= r1_idx;
            r2_val  <= r1_val;
        end
    end

    assign o_sector      = r2_sec;
    assign o_next        = r2_next;
    assign o_res         = r2_res;
    assign o_cur         = r2_cur;
    assign o_mode        = r2_mode;
    assign o_table_index = r2_idx;
    assign o_table_value = r2_val;

endmodule

// File: rtl/esq_weight.sv
// ----------------------------------------------------------------------------
// esq_weight
// Stages 3 and 4: quadratic products of the residue, then the two weights
// with the mid-sector correction.
// ----------------------------------------------------------------------------
module esq_weight import esq_pkg::*; (
    input  logic                     i_clk,
    input  t_adv                     i_adv,
    input  logic [MID_W-1:0]         i_mid_weight,
    input  logic [RES_W-1:0]         i_res,
    input  logic [SEC_W-1:0]         i_sector,
    input  logic signed [DATA_W-1:0] i_cur,
    output logic signed [WGT_W-1:0]  o_w0,
    output logic signed [WGT_W-1:0]  o_w1,
    output logic signed [DATA_W-1:0] o_cur,
    output logic [SEC_W-1:0]         o_sector
);

    logic signed [14:0]         n_r;
    logic signed [14:0]         n_rm8;
    logic signed [14:0]         n_rm4;
    logic signed [29:0]         n_pc;
    logic signed [29:0]         n_p0;
    logic signed [29:0]         n_p1;

    logic signed [PROD_W-1:0]   n_pcs;
    logic signed [MID_W:0]      n_c1;
    logic signed [MID_W:0]      n_mid;
    logic signed [2*MID_W+1:0]  n_cm;
    logic signed [2*MID_W+1:0]  n_corr;
    logic signed [PROD_W-1:0]   n_w0;
    logic signed [PROD_W-1:0]   n_w1;

    logic signed [PROD_W-1:0]   r3_pc;
    logic signed [PROD_W-1:0]   r3_p0;
    logic signed [PROD_W-1:0]   r3_p1;
    logic signed [DATA_W-1:0]   r3_cur;
    logic [SEC_W-1:0]           r3_sec;

    logic signed [WGT_W-1:0]    r4_w0;
    logic signed [WGT_W-1:0]    r4_w1;
    logic signed [DATA_W-1:0]   r4_cur;
    logic [SEC_W-1:0]           r4_sec;

    always_comb begin
        n_r    = $signed({2'b00, i_res});
        n_rm8  = n_r - 15'sd8192;
        n_rm4  = n_r - 15'sd4096;
        n_pc   = n_r * n_rm8;
        n_p0   = n_rm8 * n_rm4;
        n_p1   = n_r * n_rm4;

        n_pcs  = r3_pc >>> CORR_SHIFT;
        n_c1   = n_pcs[MID_W:0];
        n_mid  = $signed({1'b0, i_mid_weight});
        n_cm   = n_c1 * n_mid;
        n_corr = n_cm >>> MID_SHIFT;
        n_w0   = (r3_p0 >>> WGT_SHIFT) - n_corr;
        n_w1   = (r3_p1 >>> WGT_SHIFT) - n_corr;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r3_pc  <= n_pc[PROD_W-1:0];
            r3_p0  <= n_p0[PROD_W-1:0];
            r3_p1  <= n_p1[PROD_W-1:0];
            r3_cur <= i_cur;
            r3_sec <= i_sector;
        end
        if (i_adv.s4) begin
            r4_w0  <= n_w0[WGT_W-1:0];
            r4_w1  <= n_w1[WGT_W-1:0];
            r4_cur <= r3_cur;
            r4_sec <= r3_sec;
        end
    end

    assign o_w0     = r4_w0;
    assign o_w1     = r4_w1;
    assign o_cur    = r4_cur;
    assign o_sector = r4_sec;

endmodule

// File: rtl/esq_table.sv
// ----------------------------------------------------------------------------
// esq_table
// Sinusoid table, one row per sector. Written and read at stage 3, so writes
// and reads keep the order of the items; the rows are held again at stage 4.
// ----------------------------------------------------------------------------
module esq_table import esq_pkg::*; (
    input  logic              i_clk,
    input  t_adv              i_adv,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_table_index,
    input  logic [DATA_W-1:0] i_table_value,
    input  logic [SEC_W-1:0]  i_sector,
    input  logic [SEC_W-1:0]  i_next,
    output t_row              o_row0,
    output t_row              o_row1
);

    t_row              r_mem [SECTORS];
    logic              n_wr;
    logic [SEC_W-1:0]  n_row;
    logic [LANE_W-1:0] n_lane;

    t_row              r3_row0;
    t_row              r3_row1;
    t_row              r4_row0;
    t_row              r4_row1;

    always_comb begin
        n_wr   = i_wr_en && (i_table_index < IDX_W'(TABLE_DEPTH));
        n_row  = tab_row(i_table_index);
        n_lane = tab_lane(i_table_index);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            if (n_wr) begin
                r_mem[n_row][n_lane] <= i_table_value;
            end
            r3_row0 <= r_mem[i_sector];
            r3_row1 <= r_mem[i_next];
        end
        if (i_adv.s4) begin
            r4_row0 <= r3_row0;
            r4_row1 <= r3_row1;
        end
    end

    assign o_row0 = r4_row0;
    assign o_row1 = r4_row1;

endmodule

// File: rtl/esq_scale.sv
// ----------------------------------------------------------------------------
// esq_scale
// Stages 5 to 7: weight the two table rows, blend, scale by the current.
// ----------------------------------------------------------------------------
module esq_scale import esq_pkg::*; (
    input  logic                     i_clk,
    input  t_adv                     i_adv,
    input  t_row                     i_row0,
    input  t_row                     i_row1,
    input  logic signed [WGT_W-1:0]  i_w0,
    input  logic signed [WGT_W-1:0]  i_w1,
    input  logic signed [DATA_W-1:0] i_cur,
    input  logic [SEC_W-1:0]         i_sector,
    output t_row                     o_duty,
    output logic [SEC_W-1:0]         o_sector
);

    logic signed [MUL_W-1:0]   n_p0   [CHANNELS];
    logic signed [MUL_W-1:0]   n_p1   [CHANNELS];
    logic signed [MUL_W-1:0]   n_bsum [CHANNELS];
    logic signed [SCALE_W-1:0] n_prod [CHANNELS];

    logic signed [MUL_W-1:0]   r5_p0  [CHANNELS];
    logic signed [MUL_W-1:0]   r5_p1  [CHANNELS];
    logic signed [DATA_W-1:0]  r5_cur;
    logic [SEC_W-1:0]          r5_sec;

    logic signed [BLEND_W-1:0] r6_blend [CHANNELS];
    logic signed [DATA_W-1:0]  r6_cur;
    logic [SEC_W-1:0]          r6_sec;

    t_row                      r7_duty;
    logic [SEC_W-1:0]          r7_sec;

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            n_p0[ch]   = $signed(i_row0[ch]) * i_w0;
            n_p1[ch]   = $signed(i_row1[ch]) * i_w1;
            n_bsum[ch] = (r5_p0[ch] >>> BLEND_SHIFT) + (r5_p1[ch] >>> BLEND_SHIFT);
            n_prod[ch] = r6_cur * r6_blend[ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s5) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r5_p0[ch] <= n_p0[ch];
                r5_p1[ch] <= n_p1[ch];
            end
            r5_cur <= i_cur;
            r5_sec <= i_sector;
        end
        if (i_adv.s6) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r6_blend[ch] <= n_bsum[ch][BLEND_W-1:0];
            end
            r6_cur <= r5_cur;
            r6_sec <= r5_sec;
        end
        if (i_adv.s7) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r7_duty[ch] <= n_prod[ch][DUTY_SHIFT +: DATA_W];
            end
            r7_sec <= r6_sec;
        end
    end

    assign o_duty   = r7_duty;
    assign o_sector = r7_sec;

endmodule

// File: rtl/encoder_sector_quadratic_pwm.sv
// ----------------------------------------------------------------------------
// encoder_sector_quadratic_pwm
// Three-phase sinusoidal commutation from an encoder count with quadratic
// interpolation between the table rows of adjacent sectors.
//
//   channel   handshake               carries
//   input     i_valid / o_stall       mode, count, current, table index/value
//   output    o_valid / i_stall       three duties and the sector
//   config    i_cfg_valid/o_cfg_ready register index and data
//
// One item per cycle while o_stall is low; a result leaves once its item has passed every stage.
// A table write is consumed at stage 3 and yields no result.
// Each stage loads when empty or when the stage after it moves, so bubbles
// close up and a stalled output holds only the stages behind it.
// Reset clears the valid bits and the config registers; table entries are
// undefined until written.
// ----------------------------------------------------------------------------
`include "encoder_sector_quadratic_pwm_macros.svh"

module encoder_sector_quadratic_pwm import esq_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_mode,
    input  logic [DATA_W-1:0]        i_encoder_count,
    input  logic signed [DATA_W-1:0] i_current_cmd,
    input  logic [IDX_W-1:0]         i_table_index,
    input  logic signed [DATA_W-1:0] i_table_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [DATA_W-1:0]        o_duty_0,
    output logic [DATA_W-1:0]        o_duty_1,
    output logic [DATA_W-1:0]        o_duty_2,
    output logic [SEC_W-1:0]         o_sector,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data
);

    logic [DATA_W-1:0]        r_angle_offset;
    logic [MID_W-1:0]         r_mid_weight;
    logic [7:1]               r_vld;
    t_adv                     n_adv;
    logic                     n_wr_en;

    logic [SEC_W-1:0]         w_sec2;
    logic [SEC_W-1:0]         w_next2;
    logic [RES_W-1:0]         w_res2;
    logic signed [DATA_W-1:0] w_cur2;
    logic                     w_mode2;
    logic [IDX_W-1:0]         w_idx2;
    logic [DATA_W-1:0]        w_val2;

    logic signed [WGT_W-1:0]  w_w0;
    logic signed [WGT_W-1:0]  w_w1;
    logic signed [DATA_W-1:0] w_cur4;
    logic [SEC_W-1:0]         w_sec4;
    t_row                     w_row0;
    t_row                     w_row1;
    t_row                     w_duty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_offset <= '0;
            r_mid_weight   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ANGLE_OFFSET: r_angle_offset <= i_cfg_data;
                CFG_MID_WEIGHT:   r_mid_weight   <= i_cfg_data[MID_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        n_adv.s7 = !r_vld[7] || !i_stall;
        n_adv.s6 = !r_vld[6] || n_adv.s7;
        n_adv.s5 = !r_vld[5] || n_adv.s6;
        n_adv.s4 = !r_vld[4] || n_adv.s5;
        n_adv.s3 = !r_vld[3] || n_adv.s4;
        n_adv.s2 = !r_vld[2] || n_adv.s3;
        n_adv.s1 = !r_vld[1] || n_adv.s2;
        n_wr_en  = r_vld[2] && (w_mode2 == MODE_TABLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_adv.s1) begin
                r_vld[1] <= i_valid;
            end
            if (n_adv.s2) begin
                r_vld[2] <= r_vld[1];
            end
            // drop table writes here
            if (n_adv.s3) begin
                r_vld[3] <= r_vld[2] && (w_mode2 == MODE_SAMPLE);
            end
            if (n_adv.s4) begin
                r_vld[4] <= r_vld[3];
            end
            if (n_adv.s5) begin
                r_vld[5] <= r_vld[4];
            end
            if (n_adv.s6) begin
                r_vld[6] <= r_vld[5];
            end
            if (n_adv.s7) begin
                r_vld[7] <= r_vld[6];
            end
        end
    end

    assign o_stall = !n_adv.s1;
    assign o_valid = r_vld[7];

    esq_angle u_angle (
        .i_clk           (i_clk),
        .i_adv           (n_adv),
        .i_angle_offset  (r_angle_offset),
        .i_mode          (i_mode),
        .i_encoder_count (i_encoder_count),
        .i_current_cmd   (i_current_cmd),
        .i_table_index   (i_table_index),
        .i_table_value   (i_table_value),
        .o_sector        (w_sec2),
        .o_next          (w_next2),
        .o_res           (w_res2),
        .o_cur           (w_cur2),
        .o_mode          (w_mode2),
        .o_table_index   (w_idx2),
        .o_table_value   (w_val2)
    );

    esq_weight u_weight (
        .i_clk        (i_clk),
        .i_adv        (n_adv),
        .i_mid_weight (r_mid_weight),
        .i_res        (w_res2),
        .i_sector     (w_sec2),
        .i_cur        (w_cur2),
        .o_w0         (w_w0),
        .o_w1         (w_w1),
        .o_cur        (w_cur4),
        .o_sector     (w_sec4)
    );

    esq_table u_table (
        .i_clk         (i_clk),
        .i_adv         (n_adv),
        .i_wr_en       (n_wr_en),
        .i_table_index (w_idx2),
        .i_table_value (w_val2),
        .i_sector      (w_sec2),
        .i_next        (w_next2),
        .o_row0        (w_row0),
        .o_row1        (w_row1)
    );

    esq_scale u_scale (
        .i_clk    (i_clk),
        .i_adv    (n_adv),
        .i_row0   (w_row0),
        .i_row1   (w_row1),
        .i_w0     (w_w0),
        .i_w1     (w_w1),
        .i_cur    (w_cur4),
        .i_sector (w_sec4),
        .o_duty   (w_duty),
        .o_sector (o_sector)
    );

    assign o_duty_0 = w_duty[0];
    assign o_duty_1 = w_duty[1];
    assign o_duty_2 = w_duty[2];

    `ESQ_ASSERT_IMP(ast_sector_range, o_valid, o_sector <= SEC_W'(SECTORS - 1), "sector out of range")
    `ESQ_ASSERT_IMP(ast_full_stall, (&r_vld) && i_stall, o_stall, "full pipeline took an item")
    `ESQ_ASSERT_NXT(ast_write_dropped, n_wr_en && n_adv.s3, !r_vld[3], "table write went on")
    `ESQ_ASSERT_NXT(ast_stage_hold, r_vld[4] && !n_adv.s4, r_vld[4], "held stage lost its item")

endmodule

// File: tb/sv/encoder_sector_quadratic_pwm_test.sv
// ----------------------------------------------------------------------------
// encoder_sector_quadratic_pwm_test
// Self-checking bench for the sector commutation block. It fills the sine
// table, runs directed samples at the angle, sector and current extremes, then
// random mixes of table writes and samples under several register settings.
// A tracker class mirrors the table and registers, predicts the three duties
// and the sector of each sample and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module encoder_sector_quadratic_pwm_test;
    import esq_pkg::*;

    typedef struct packed {
        logic                     mode;
        logic [DATA_W-1:0]        count;
        logic signed [DATA_W-1:0] current;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
    } drive_t;

    typedef struct packed {
        logic [DATA_W-1:0] duty0;
        logic [DATA_W-1:0] duty1;
        logic [DATA_W-1:0] duty2;
        logic [SEC_W-1:0]  sector;
    } duty_t;

    class commutation_tracker;
        logic signed [DATA_W-1:0] sine_row [TABLE_DEPTH];
        logic [DATA_W-1:0]        offset;
        logic [MID_W-1:0]         mid;
        duty_t                    duties_due [$];
        int unsigned              faults;

        function new();
            offset = '0;
            mid    = '0;
            faults = 0;
            foreach (sine_row[k]) sine_row[k] = '0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [DATA_W-1:0] data);
            if (idx == CFG_ANGLE_OFFSET) begin
                offset = data;
            end else begin
                mid = data[MID_W-1:0];
            end
        endfunction

        function duty_t compute_duties(drive_t it);
            logic [ANG_W-1:0]  ang;
            logic [SEC_W-1:0]  sec;
            logic [SEC_W-1:0]  nsec;
            longint            r, corr, w0, w1, cur, t0, t1, blend, scaled;
            logic [DATA_W-1:0] lane [CHANNELS];
            duty_t             res;
            ang  = ANG_W'(it.count) - ANG_W'(offset);
            ang  = ang * ANG_W'(ANGLE_MUL);
            ang  = ang % ANG_W'(CHANNELS << 14);
            sec  = SEC_W'(ang >> RES_W);
            nsec = (sec == SEC_W'(SECTORS - 1)) ? '0 : sec + 1'b1;
            r    = longint'(ang) - (longint'(sec) << RES_W);
            corr = (r * (r - SECTOR_FULL)) >>> CORR_SHIFT;
            corr = (corr * longint'(mid)) >>> MID_SHIFT;
            w0   = (((r - SECTOR_FULL) * (r - SECTOR_HALF)) >>> WGT_SHIFT) - corr;
            w1   = ((r * (r - SECTOR_HALF)) >>> WGT_SHIFT) - corr;
            cur  = longint'($signed(it.current));
            for (int ch = 0; ch < CHANNELS; ch++) begin
                t0       = longint'($signed(sine_row[int'(sec) * CHANNELS + ch]));
                t1       = longint'($signed(sine_row[int'(nsec) * CHANNELS + ch]));
                blend    = ((t0 * w0) >>> BLEND_SHIFT) + ((t1 * w1) >>> BLEND_SHIFT);
                scaled   = (cur * blend) >>> DUTY_SHIFT;
                lane[ch] = scaled[DATA_W-1:0];
            end
            res.duty0  = lane[0];
            res.duty1  = lane[1];
            res.duty2  = lane[2];
            res.sector = sec;
            return res;
        endfunction

        function void take_item(drive_t it);
            if (it.mode == MODE_TABLE) begin
                if (it.index < TABLE_DEPTH) begin
                    sine_row[it.index] = it.value;
                end
            end else begin
                duties_due.push_back(compute_duties(it));
            end
        endfunction

        function void check_duties(duty_t got);
            duty_t want;
            if (duties_due.size() == 0) begin
                faults++;
                if (faults <= 10) begin
                    $display("%0t unexpected result: d0=%h d1=%h d2=%h sector=%0d",
                             $realtime, got.duty0, got.duty1, got.duty2, got.sector);
                end
                return;
            end
            want = duties_due.pop_front();
            if (got.duty0 !== want.duty0 || got.duty1 !== want.duty1 ||
                got.duty2 !== want.duty2 || got.sector !== want.sector) begin
                faults++;
                if (faults <= 10) begin
                    $display("%0t duty error: expected d0=%h d1=%h d2=%h sector=%0d",
                             $realtime, want.duty0, want.duty1, want.duty2, want.sector);
                    $display("%0t             actual   d0=%h d1=%h d2=%h sector=%0d",
                             $realtime, got.duty0, got.duty1, got.duty2, got.sector);
                end
            end
        endfunction

        function int pending();
            return duties_due.size();
        endfunction
    endclass

    localparam int RX_HOLD = 300;
    localparam int SETTLE  = 16;
    localparam int PHASES  = 5;
    localparam int PHASE_N = 260;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic                     i_mode = MODE_SAMPLE;
    logic [DATA_W-1:0]        i_encoder_count = '0;
    logic signed [DATA_W-1:0] i_current_cmd = '0;
    logic [IDX_W-1:0]         i_table_index = '0;
    logic signed [DATA_W-1:0] i_table_value = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [DATA_W-1:0]        o_duty_0;
    logic [DATA_W-1:0]        o_duty_1;
    logic [DATA_W-1:0]        o_duty_2;
    logic [SEC_W-1:0]         o_sector;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic                     i_cfg_index = CFG_ANGLE_OFFSET;
    logic [DATA_W-1:0]        i_cfg_data = '0;

    commutation_tracker tracker;
    int  tx_idle = 36;
    int  rx_idle = 36;
    bit  rx_hold = 1'b0;

    encoder_sector_quadratic_pwm u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_encoder_count (i_encoder_count),
        .i_current_cmd   (i_current_cmd),
        .i_table_index   (i_table_index),
        .i_table_value   (i_table_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_duty_0        (o_duty_0),
        .o_duty_1        (o_duty_1),
        .o_duty_2        (o_duty_2),
        .o_sector        (o_sector),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic drive_t sample(logic [DATA_W-1:0] count, logic [DATA_W-1:0] cur);
        drive_t it;
        it.mode    = MODE_SAMPLE;
        it.count   = count;
        it.current = cur;
        it.index   = IDX_W'($urandom_range(31));
        it.value   = DATA_W'($urandom);
        return it;
    endfunction

    function automatic drive_t entry(int idx, logic [DATA_W-1:0] val);
        drive_t it;
        it.mode    = MODE_TABLE;
        it.count   = DATA_W'($urandom);
        it.current = DATA_W'($urandom);
        it.index   = IDX_W'(idx);
        it.value   = val;
        return it;
    endfunction

    function automatic drive_t random_item();
        int idx;
        idx = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(TABLE_DEPTH - 1);
        if ($urandom_range(99) < 20) begin
            return entry(idx, DATA_W'($urandom));
        end
        return sample(DATA_W'($urandom), DATA_W'($urandom));
    endfunction

    task automatic send_item(input drive_t it);
        while ($urandom_range(99) < tx_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_mode          <= it.mode;
        i_encoder_count <= it.count;
        i_current_cmd   <= it.current;
        i_table_index   <= it.index;
        i_table_value   <= it.value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.take_item(it);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.set_register(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle_block();
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // receiver: random stall, with one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                i_stall <= 1'b1;
                repeat (RX_HOLD) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            i_stall <= ($urandom_range(99) < rx_idle);
        end
    end

    always @(posedge i_clk) begin
        duty_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.duty0  = o_duty_0;
            got.duty1  = o_duty_1;
            got.duty2  = o_duty_2;
            got.sector = o_sector;
            tracker.check_duties(got);
        end
    end

    initial begin
        int k;
        int ph;
        int n;
        tracker = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_reg(CFG_ANGLE_OFFSET, 16'd0);
        write_reg(CFG_MID_WEIGHT, 16'd0);

        for (k = 0; k < TABLE_DEPTH; k++) begin
            send_item(entry(k, (k == TABLE_DEPTH - 1) ? 16'h7FFF : DATA_W'(k * 3855 - 32768)));
        end
        send_item(entry(TABLE_DEPTH, 16'h1234));
        send_item(entry(31, 16'hFFFF));
        send_item(sample(16'd0, 16'h7FFF));
        send_item(sample(16'hFFFF, 16'h8000));
        send_item(sample(16'd4096, 16'hFFFF));
        send_item(sample(16'd8192, 16'd0));
        send_item(sample(16'd2000, 16'h7FFF));
        send_item(sample(16'd1, 16'h8000));
        send_item(entry(0, 16'h8000));
        send_item(sample(16'd2000, 16'h7FFF));
        settle_block();
        write_reg(CFG_ANGLE_OFFSET, 16'hFFFF);
        write_reg(CFG_MID_WEIGHT, 16'd1023);
        send_item(sample(16'd0, 16'h7FFF));
        send_item(sample(16'hFFFF, 16'h8000));
        send_item(sample(16'd4096, 16'd1));

        for (ph = 0; ph < PHASES; ph++) begin
            settle_block();
            case (ph)
                0: begin
                    write_reg(CFG_ANGLE_OFFSET, 16'd0);
                    write_reg(CFG_MID_WEIGHT, 16'd1023);
                end
                1: begin
                    write_reg(CFG_ANGLE_OFFSET, 16'hFFFF);
                    write_reg(CFG_MID_WEIGHT, 16'd0);
                end
                4: begin
                    write_reg(CFG_ANGLE_OFFSET, DATA_W'($urandom));
                    write_reg(CFG_MID_WEIGHT, 16'd1023);
                end
                default: begin
                    write_reg(CFG_ANGLE_OFFSET, DATA_W'($urandom));
                    write_reg(CFG_MID_WEIGHT, DATA_W'($urandom_range(1023)));
                end
            endcase
            tx_idle = (ph == 2 || ph == 3) ? 0 : 36;
            rx_idle = (ph == 3) ? 0 : 36;
            if (ph == 2) begin
                rx_hold = 1'b1;
            end
            for (n = 0; n < PHASE_N; n++) begin
                if (ph == 2 && n == 80) begin
                    tx_idle = 36;
                end
                send_item(random_item());
            end
        end

        settle_block();
        if (tracker.faults == 0 && tracker.pending() == 0) begin
            $display("encoder_sector_quadratic_pwm: match");
        end else begin
            $display("encoder_sector_quadratic_pwm: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("encoder_sector_quadratic_pwm: mismatch");
        $finish;
    end

endmodule
